/* hw/rtl/lphm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants for the linear probing hash map: FNV-1a prime with a
// nonstandard offset basis, operation, status and bucket state codes.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  // prime = 2^40 + 0x1b3
  localparam int          FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'h1b3;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_INVALID   = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [6:0] LIMIT_RESET = 7'd38;

endpackage

/* hw/rtl/lphm_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_hash
// Iterative 64-bit FNV-1a-style hash over eight key bytes, one byte per cycle.
// ----------------------------------------------------------------------------
module lphm_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] hash_o
);
  import lphm_pkg::*;

  logic        run_q, run_d;
  logic [2:0]  rnd_q, rnd_d;
  logic [63:0] h_q, h_d;
  logic [63:0] key_q, key_d;
  logic        done_q, done_d;
  logic [63:0] x;

  // x * prime as shift plus narrow multiply
  assign x = h_q ^ {56'd0, key_q[7:0]};

  always_comb begin
    run_d  = run_q;
    rnd_d  = rnd_q;
    h_d    = h_q;
    key_d  = key_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      rnd_d = 3'd0;
      h_d   = FNV_BASIS;
      key_d = key_i;
    end else if (run_q) begin
      h_d   = (x << FNV_SHIFT) + (x * {55'd0, FNV_LOW});
      key_d = key_q >> 8;
      rnd_d = rnd_q + 3'd1;
      if (rnd_q == 3'd7) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      rnd_q  <= rnd_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    key_q <= key_d;
  end

  assign done_o = done_q;
  assign hash_o = (h_q == 64'd0) ? FNV_BASIS : h_q;

endmodule

/* hw/rtl/linear_probe_hash_map_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// Key-value map over a fixed bucket table, FNV-1a-style hash, linear
// probing with tombstones.
// ----------------------------------------------------------------------------
// One operation at a time: an item is taken when start_i is high and busy_o
// low, and its result shows on done_o for one cycle, which the receiver
// cannot stall. A set, get or delete hashes the key one byte per cycle
// through the shared FNV round, then probes bucket by bucket, each probe a
// registered read of the bucket memories (S_RD) and a compare (S_CHK), and
// then reports. A set or get with an invalid key reports in the next cycle.
// Clear, and reset, sweep the bucket state memory one bucket per
// cycle, with busy_o high until the sweep ends.
// BUCKETS must be a power of two; the hash's low bits pick the start bucket.
module linear_probe_hash_map_core #(
  parameter int BUCKETS    = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] key_i,
  input  logic        key_valid_i,
  input  logic [63:0] value_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] value_out_o,
  output logic        found_o,
  output logic        collision_o,
  output logic [6:0]  live_count_o
);
  import lphm_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  logic [63:0]           key_mem [BUCKETS];
  logic [VALUE_BITS-1:0] val_mem [BUCKETS];
  logic [1:0]            st_mem  [BUCKETS];

  logic [63:0]           key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [1:0]            st_rd_q;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] clr_idx_q, clr_idx_d;
  logic          clr_rsp_q, clr_rsp_d;
  logic [CW-1:0] steps_q, steps_d;
  logic          tomb_seen_q, tomb_seen_d;
  logic [IW-1:0] tomb_at_q, tomb_at_d;
  logic [CW-1:0] count_q, count_d;
  logic [6:0]    limit_q;

  logic [1:0]            kind_q;
  logic [63:0]           key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic [63:0]           vout_q, vout_d;
  logic                  found_q, found_d;
  logic                  coll_q, coll_d;

  logic                  hash_start, hash_done;
  logic [63:0]           hash;

  logic                  key_we, val_we, st_we;
  logic [IW-1:0]         wr_addr;
  logic [1:0]            wr_st;

  logic                  fin, hit, has_free, coll;
  logic [IW-1:0]         at;
  logic [LW-1:0]         lim;

  lphm_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_i),
    .done_o (hash_done),
    .hash_o (hash)
  );

  assign lim = (LW'(limit_q) > LW'(BUCKETS)) ? LW'(BUCKETS) : LW'(limit_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    clr_idx_d   = clr_idx_q;
    clr_rsp_d   = clr_rsp_q;
    steps_d     = steps_q;
    tomb_seen_d = tomb_seen_q;
    tomb_at_d   = tomb_at_q;
    count_d     = count_q;
    done_d      = 1'b0;
    status_d    = status_q;
    vout_d      = vout_q;
    found_d     = found_q;
    coll_d      = coll_q;
    hash_start  = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    st_we       = 1'b0;
    wr_addr     = idx_q;
    wr_st       = SLOT_LIVE;
    fin         = 1'b0;
    hit         = 1'b0;
    has_free    = 1'b0;
    coll        = 1'b0;
    at          = idx_q;

    case (state_q)
      S_CLR: begin
        st_we     = 1'b1;
        wr_addr   = clr_idx_q;
        wr_st     = SLOT_EMPTY;
        clr_idx_d = clr_idx_q + IW'(1);
        if (clr_idx_q == IW'(BUCKETS - 1)) begin
          state_d   = S_IDLE;
          clr_rsp_d = 1'b0;
          if (clr_rsp_q) begin
            done_d   = 1'b1;
            status_d = STATUS_OK;
            vout_d   = 64'd0;
            found_d  = 1'b0;
            coll_d   = 1'b0;
          end
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_CLEAR) begin
            count_d   = '0;
            clr_idx_d = '0;
            clr_rsp_d = 1'b1;
            state_d   = S_CLR;
          end else if (kind_i != KIND_DEL && !key_valid_i) begin
            done_d   = 1'b1;
            status_d = (kind_i == KIND_SET) ? STATUS_INVALID : STATUS_NOT_FOUND;
            vout_d   = 64'd0;
            found_d  = 1'b0;
            coll_d   = 1'b0;
          end else begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d       = hash[IW-1:0];
          steps_d     = '0;
          tomb_seen_d = 1'b0;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        coll = (steps_q != '0);
        if (st_rd_q == SLOT_EMPTY) begin
          fin      = 1'b1;
          has_free = 1'b1;
          at       = tomb_seen_q ? tomb_at_q : idx_q;
        end else if (st_rd_q == SLOT_LIVE && key_rd_q == key_q) begin
          fin = 1'b1;
          hit = 1'b1;
        end else begin
          if (st_rd_q != SLOT_LIVE && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_at_d   = idx_q;
          end
          idx_d   = idx_q + IW'(1);
          steps_d = steps_q + CW'(1);
          state_d = S_RD;
          if (steps_q + CW'(1) == CW'(BUCKETS)) begin
            // whole table walked without an empty bucket
            fin      = 1'b1;
            coll     = 1'b1;
            has_free = tomb_seen_q || st_rd_q != SLOT_LIVE;
            at       = tomb_seen_q ? tomb_at_q : idx_q;
          end
        end

        if (fin) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          wr_addr  = at;
          status_d = STATUS_OK;
          vout_d   = 64'd0;
          found_d  = 1'b0;
          coll_d   = coll;
          case (kind_q)
            KIND_SET: begin
              if (hit) begin
                val_we = 1'b1;
              end else if (LW'(count_q) >= lim || !has_free) begin
                status_d = STATUS_FULL;
              end else begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                st_we   = 1'b1;
                wr_st   = SLOT_LIVE;
                count_d = count_q + CW'(1);
              end
            end
            KIND_GET: begin
              if (hit) begin
                vout_d  = 64'(val_rd_q);
                found_d = 1'b1;
              end else begin
                status_d = STATUS_NOT_FOUND;
              end
            end
            default: begin
              if (hit) begin
                st_we   = 1'b1;
                wr_st   = SLOT_TOMB;
                found_d = 1'b1;
                if (count_q != '0) count_d = count_q - CW'(1);
              end
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_idx_q   <= '0;
      clr_rsp_q   <= 1'b0;
      count_q     <= '0;
      limit_q     <= LIMIT_RESET;
      done_q      <= 1'b0;
      idx_q       <= '0;
      steps_q     <= '0;
      tomb_seen_q <= 1'b0;
      tomb_at_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      clr_rsp_q   <= clr_rsp_d;
      count_q     <= count_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      tomb_seen_q <= tomb_seen_d;
      tomb_at_q   <= tomb_at_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    vout_q   <= vout_d;
    found_q  <= found_d;
    coll_q   <= coll_d;
    if (state_q == S_IDLE && start_i) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      val_q  <= value_in_i[VALUE_BITS-1:0];
    end
  end

  // bucket memories: one write port, one registered read at the probe index
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= key_q;
    key_rd_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[wr_addr] <= val_q;
    val_rd_q <= val_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[wr_addr] <= wr_st;
    st_rd_q <= st_mem[idx_q];
  end

  assign busy_o       = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign value_out_o  = vout_q;
  assign found_o      = found_q;
  assign collision_o  = coll_q;
  assign live_count_o = 7'(count_q);

endmodule

/* hw/rtl/lphm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_checker
// Port-level checks on the hash map core, bound into linear_probe_hash_map_core.
// ----------------------------------------------------------------------------
module lphm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [63:0] value_out_o,
  input logic        found_o
);
  import lphm_pkg::*;

  // a result ends a busy period or follows an immediately rejected transfer
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o || start_i))
    else $error("result without a pending operation");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("transfer accepted but no work started");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == STATUS_OK))
    else $error("found with non-ok status");

  a_value_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && value_out_o != 64'd0) |-> found_o)
    else $error("value returned without a hit");

endmodule

bind linear_probe_hash_map_core lphm_checker u_lphm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .status_o   (status_o),
  .value_out_o(value_out_o),
  .found_o    (found_o)
);
